@@ hdl/tct_pkg.sv @@
// Package for the transition count table: operation codes, table geometry,
// the pattern decode function and the command type passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package tct_pkg;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  localparam int PAT_COUNT   = 90;
  localparam int PAT_BITS    = 14;
  localparam int PAT_IDX_W   = 7;
  localparam int LOAD_BITS   = 32;
  localparam int COUNT_OUT_W = 32;

  localparam int NUM_ACTIONS_DEF = 6;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic                 ok;
    logic [PAT_IDX_W-1:0] idx;
  } pat_t;

  typedef struct packed {
    logic                 hit;
    logic [1:0]           op;
    logic [LOAD_BITS-1:0] load_value;
  } cmd_t;

  // three-hot check and index a*18 + b*3 + c
  function automatic pat_t pattern_decode(input logic [PAT_BITS-1:0] p);
    pat_t       r;
    logic [4:0] ga;
    logic [5:0] gb;
    logic [2:0] gc;
    logic [2:0] a;
    logic [2:0] b;
    logic [1:0] c;
    ga = p[4:0];
    gb = p[10:5];
    gc = p[13:11];
    a = '0;
    b = '0;
    c = '0;
    for (int i = 0; i < 5; i++) begin
      if (ga[i]) a = 3'(i);
    end
    for (int i = 0; i < 6; i++) begin
      if (gb[i]) b = 3'(i);
    end
    for (int i = 0; i < 3; i++) begin
      if (gc[i]) c = 2'(i);
    end
    r.ok = (ga != 5'd0) && ((ga & (ga - 5'd1)) == 5'd0) &&
           (gb != 6'd0) && ((gb & (gb - 6'd1)) == 6'd0) &&
           (gc != 3'd0) && ((gc & (gc - 3'd1)) == 3'd0);
    r.idx = PAT_IDX_W'(int'(a) * 18 + int'(b) * 3 + int'(c));
    return r;
  endfunction

endpackage

@@ hdl/tct_front.sv @@
// Front end: accepts requests, validates operation, patterns and action, forms the table address.
// Depends on tct_pkg.
`timescale 1ns / 1ps

module tct_front #(
  parameter int NUM_ACTIONS = tct_pkg::NUM_ACTIONS_DEF,
  parameter int ADDR_W      = 16
) (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   operation,
  input  logic [tct_pkg::PAT_BITS-1:0] current_pattern,
  input  logic [2:0]                   action,
  input  logic [tct_pkg::PAT_BITS-1:0] next_pattern,
  input  logic [tct_pkg::LOAD_BITS-1:0] load_value,
  input  logic                         clearing,
  input  logic                         q_ready,
  output logic                         q_valid,
  output tct_pkg::cmd_t                cmd,
  output logic [ADDR_W-1:0]            addr
);

  tct_pkg::pat_t p_dec;
  tct_pkg::pat_t q_dec;
  logic          act_ok;
  logic          op_ok;

  assign p_dec  = tct_pkg::pattern_decode(current_pattern);
  assign q_dec  = tct_pkg::pattern_decode(next_pattern);
  assign act_ok = {1'b0, action} < 4'(NUM_ACTIONS);
  assign op_ok  = (operation == tct_pkg::OP_RECORD) || (operation == tct_pkg::OP_READ) ||
                  (operation == tct_pkg::OP_LOAD);

  assign cmd.hit        = op_ok && act_ok && p_dec.ok && q_dec.ok;
  assign cmd.op         = operation;
  assign cmd.load_value = load_value;

  assign addr = ADDR_W'((int'(p_dec.idx) * NUM_ACTIONS + int'(action)) * tct_pkg::PAT_COUNT
                        + int'(q_dec.idx));

  assign in_ready = q_ready && !clearing;
  assign q_valid  = in_valid && !clearing;

endmodule

@@ hdl/tct_queue.sv @@
// Short FIFO between front and back ends.
// Depends on tct_pkg.
`timescale 1ns / 1ps

module tct_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int D   = tct_pkg::QUEUE_DEPTH;
  localparam int PW  = (D > 1) ? $clog2(D) : 1;
  localparam int CW  = $clog2(D + 1);

  logic [W-1:0]  slots [D];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = fill != CW'(D);
  assign pop_valid  = fill != '0;
  assign pop_data   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(D - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(D - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

@@ hdl/tct_back.sv @@
// Back end: clearing pass, table memory read-modify-write and output register.
// Depends on tct_pkg.
`timescale 1ns / 1ps

module tct_back #(
  parameter int COUNT_BITS = tct_pkg::COUNT_BITS_DEF,
  parameter int DEPTH      = 48600,
  parameter int ADDR_W     = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           clearing,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  tct_pkg::cmd_t                  q_cmd,
  input  logic [ADDR_W-1:0]              q_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           matched,
  output logic [tct_pkg::COUNT_OUT_W-1:0] count
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MOD   = 2'd2;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] new_val;
  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [ADDR_W-1:0]     clr_addr;
  tct_pkg::cmd_t         cur_cmd;
  logic [ADDR_W-1:0]     cur_addr;
  logic                  out_free;
  logic                  re;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic                  take_miss;
  logic                  finish;

  assign clearing = state == ST_CLEAR;
  assign out_free = !out_valid || out_ready;

  assign take_miss = (state == ST_IDLE) && q_valid && !q_cmd.hit && out_free;
  assign re        = (state == ST_IDLE) && q_valid && q_cmd.hit;
  assign q_ready   = take_miss || re;
  assign finish    = (state == ST_MOD) && out_free;

  always_comb begin
    unique case (cur_cmd.op)
      tct_pkg::OP_RECORD: new_val = (rdata == '1) ? rdata : rdata + COUNT_BITS'(1);
      tct_pkg::OP_LOAD:   new_val = COUNT_BITS'(cur_cmd.load_value);
      default:            new_val = rdata;
    endcase
  end

  assign we    = clearing || (finish && (cur_cmd.op != tct_pkg::OP_READ));
  assign waddr = clearing ? clr_addr : cur_addr;
  assign wdata = clearing ? '0 : new_val;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[q_addr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (re) state_next = ST_MOD;
      ST_MOD:   if (finish) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (re) begin
      cur_cmd  <= q_cmd;
      cur_addr <= q_addr;
    end
    if (take_miss) begin
      matched <= 1'b0;
      count   <= '0;
    end else if (finish) begin
      matched <= 1'b1;
      count   <= tct_pkg::COUNT_OUT_W'(new_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (take_miss || finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/transition_count_table_unit.sv @@
// Transition count table: saturating counts per (pattern, action, next pattern).
// A matched request is handled as a memory read, then update and write back; the table
// takes no new request in between. A rejected request needs no table access: one rejected
// request per cycle while the output is not stalled; a 2-entry queue decouples input from table update.
// Reset: a clearing pass over all 8100*NUM_ACTIONS entries zeroes the table; no input taken meanwhile.
`timescale 1ns / 1ps

module transition_count_table_unit #(
  parameter int NUM_ACTIONS = tct_pkg::NUM_ACTIONS_DEF,
  parameter int COUNT_BITS  = tct_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      operation,
  input  logic [tct_pkg::PAT_BITS-1:0]    current_pattern,
  input  logic [2:0]                      action,
  input  logic [tct_pkg::PAT_BITS-1:0]    next_pattern,
  input  logic [tct_pkg::LOAD_BITS-1:0]   load_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            matched,
  output logic [tct_pkg::COUNT_OUT_W-1:0] count
);

  localparam int DEPTH  = tct_pkg::PAT_COUNT * NUM_ACTIONS * tct_pkg::PAT_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int QW     = $bits(tct_pkg::cmd_t) + ADDR_W;

  logic              clearing;
  logic              f_valid;
  logic              f_ready;
  tct_pkg::cmd_t     f_cmd;
  logic [ADDR_W-1:0] f_addr;
  logic              b_valid;
  logic              b_ready;
  tct_pkg::cmd_t     b_cmd;
  logic [ADDR_W-1:0] b_addr;
  logic [QW-1:0]     q_in;
  logic [QW-1:0]     q_out;

  tct_front #(
    .NUM_ACTIONS(NUM_ACTIONS),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .current_pattern(current_pattern),
    .action         (action),
    .next_pattern   (next_pattern),
    .load_value     (load_value),
    .clearing       (clearing),
    .q_ready        (f_ready),
    .q_valid        (f_valid),
    .cmd            (f_cmd),
    .addr           (f_addr)
  );

  assign q_in = {f_cmd, f_addr};

  tct_queue #(
    .W(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (q_in),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (q_out)
  );

  assign {b_cmd, b_addr} = q_out;

  tct_back #(
    .COUNT_BITS(COUNT_BITS),
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_cmd    (b_cmd),
    .q_addr   (b_addr),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .matched  (matched),
    .count    (count)
  );

endmodule

@@ tb/tct_checker.sv @@
// Checker for the transition count table: watches both channels, keeps its own copy
// of the count table, predicts each result and compares it field by field.
// Depends on tct_pkg.
`timescale 1ns / 1ps

module tct_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      operation,
  input  logic [tct_pkg::PAT_BITS-1:0]    current_pattern,
  input  logic [2:0]                      action,
  input  logic [tct_pkg::PAT_BITS-1:0]    next_pattern,
  input  logic [tct_pkg::LOAD_BITS-1:0]   load_value,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            matched,
  input  logic [tct_pkg::COUNT_OUT_W-1:0] count,
  output int                              mismatches,
  output int                              outstanding
);
  import tct_pkg::*;

  localparam int N_ACT = NUM_ACTIONS_DEF;
  localparam int TABLE_SIZE = PAT_COUNT * N_ACT * PAT_COUNT;

  typedef struct packed {
    logic                   hit;
    logic [COUNT_OUT_W-1:0] value;
  } result_t;

  logic [COUNT_BITS_DEF-1:0] counts [TABLE_SIZE];
  result_t                   expected_q [$];

  // position of the single set bit, -1 unless exactly one bit is set
  function automatic int group_pos(input logic [5:0] bits, input int width);
    int pos;
    int ones;
    pos = -1;
    ones = 0;
    for (int i = 0; i < width; i++) begin
      if (bits[i]) begin
        ones++;
        pos = i;
      end
    end
    return (ones == 1) ? pos : -1;
  endfunction

  function automatic int pattern_slot(input logic [PAT_BITS-1:0] p);
    int a;
    int b;
    int c;
    a = group_pos(6'(p[4:0]), 5);
    b = group_pos(p[10:5], 6);
    c = group_pos(6'(p[13:11]), 3);
    if (a < 0 || b < 0 || c < 0) return -1;
    return a * 18 + b * 3 + c;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    int      p;
    int      q;
    int      slot;
    if (rst) begin
      foreach (counts[i]) counts[i] = '0;
      expected_q.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 32'd0, count);
        end else begin
          want = expected_q.pop_front();
          if (matched !== want.hit) report("matched", 32'(want.hit), 32'(matched));
          if (count !== want.value) report("count", want.value, count);
        end
      end
      if (in_valid && in_ready) begin
        p = pattern_slot(current_pattern);
        q = pattern_slot(next_pattern);
        want = '0;
        if (p >= 0 && q >= 0 && int'(action) < N_ACT) begin
          slot = (p * N_ACT + int'(action)) * PAT_COUNT + q;
          want.hit = 1'b1;
          case (operation)
            OP_RECORD: begin
              if (counts[slot] != '1) counts[slot] = counts[slot] + 1'b1;
            end
            OP_READ: begin
            end
            OP_LOAD: begin
              counts[slot] = COUNT_BITS_DEF'(load_value);
            end
            default: begin
              want.hit = 1'b0;
            end
          endcase
          if (want.hit) want.value = COUNT_OUT_W'(counts[slot]);
        end
        expected_q.push_back(want);
      end
      outstanding <= expected_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for transition_count_table_unit: directed and random requests with
// random idling on both sides, verdict from the failure count of tct_checker.
// Depends on tct_pkg, transition_count_table_unit and tct_checker.
`timescale 1ns / 1ps

module tb_top;
  import tct_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int N_ACT      = NUM_ACTIONS_DEF;
  localparam int N_RANDOM   = 880;
  localparam int CALM_TAIL  = 150;
  localparam int IDLE_LIMIT = 150000;
  localparam int HOLD_LEN   = 80;
  localparam int POOL_SIZE  = 8;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             operation = OP_RECORD;
  logic [PAT_BITS-1:0]    current_pattern = '0;
  logic [2:0]             action = '0;
  logic [PAT_BITS-1:0]    next_pattern = '0;
  logic [LOAD_BITS-1:0]   load_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   matched;
  logic [COUNT_OUT_W-1:0] count;

  int   mismatches;
  int   outstanding;
  int   idle_cycles = 0;
  logic send_idle_on = 1'b0;
  logic sink_stall_on = 1'b0;
  logic long_hold = 1'b0;
  logic hold_done = 1'b0;

  logic [PAT_BITS-1:0] pool_cur [POOL_SIZE];
  logic [2:0]          pool_act [POOL_SIZE];
  logic [PAT_BITS-1:0] pool_next [POOL_SIZE];

  always #5 clk = ~clk;

  transition_count_table_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .current_pattern(current_pattern), .action(action),
    .next_pattern(next_pattern), .load_value(load_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .matched(matched), .count(count)
  );

  tct_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .current_pattern(current_pattern), .action(action),
    .next_pattern(next_pattern), .load_value(load_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .matched(matched), .count(count),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: long hold on request, random stall bursts otherwise
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done <= 1'b1;
        out_ready <= 1'b1;
      end else if (sink_stall_on && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [PAT_BITS-1:0] make_pattern(input int a, input int b, input int c);
    logic [PAT_BITS-1:0] p;
    p = '0;
    p[a] = 1'b1;
    p[5 + b] = 1'b1;
    p[11 + c] = 1'b1;
    return p;
  endfunction

  function automatic logic [PAT_BITS-1:0] any_valid_pattern();
    return make_pattern($urandom_range(0, 4), $urandom_range(0, 5), $urandom_range(0, 2));
  endfunction

  task automatic offer(input logic [1:0] op, input logic [PAT_BITS-1:0] cur,
                       input logic [2:0] act, input logic [PAT_BITS-1:0] nxt,
                       input logic [LOAD_BITS-1:0] lv);
    in_valid        <= 1'b1;
    operation       <= op;
    current_pattern <= cur;
    action          <= act;
    next_pattern    <= nxt;
    load_value      <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [LOAD_BITS-1:0] pick_load_value();
    case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      1: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int                   kind;
    int                   k;
    logic [1:0]           op;
    logic [PAT_BITS-1:0]  cur;
    logic [PAT_BITS-1:0]  nxt;
    logic [2:0]           act;
    kind = $urandom_range(0, 99);
    k = $urandom_range(0, POOL_SIZE - 1);
    op = ($urandom_range(0, 9) < 6) ? OP_RECORD : ($urandom_range(0, 1) ? OP_READ : OP_LOAD);
    cur = pool_cur[k];
    act = pool_act[k];
    nxt = pool_next[k];
    if (kind >= 55 && kind < 75) begin
      cur = any_valid_pattern();
      nxt = any_valid_pattern();
      act = 3'($urandom_range(0, N_ACT - 1));
    end else if (kind >= 75 && kind < 90) begin
      op  = 2'($urandom_range(0, 3));
      cur = PAT_BITS'($urandom);
      nxt = PAT_BITS'($urandom);
      act = 3'($urandom_range(0, 7));
    end else if (kind >= 90) begin
      case ($urandom_range(0, 3))
        0: act = 3'($urandom_range(N_ACT, 7));
        1: op = OP_NONE;
        2: cur[$urandom_range(0, PAT_BITS - 1)] ^= 1'b1;
        default: nxt[$urandom_range(0, PAT_BITS - 1)] ^= 1'b1;
      endcase
    end
    offer(op, cur, act, nxt, pick_load_value());
  endtask

  initial begin
    logic [PAT_BITS-1:0] lo_pat;
    logic [PAT_BITS-1:0] hi_pat;
    lo_pat = make_pattern(0, 0, 0);
    hi_pat = make_pattern(4, 5, 2);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_cur[i]  = any_valid_pattern();
      pool_act[i]  = 3'($urandom_range(0, N_ACT - 1));
      pool_next[i] = any_valid_pattern();
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    offer(OP_READ,   lo_pat, 3'd0, lo_pat, 32'h0);
    offer(OP_RECORD, lo_pat, 3'd0, lo_pat, 32'hFFFF_FFFF);
    offer(OP_RECORD, lo_pat, 3'd0, lo_pat, 32'h0);
    offer(OP_READ,   lo_pat, 3'd0, lo_pat, 32'h0);
    offer(OP_RECORD, hi_pat, 3'(N_ACT - 1), hi_pat, 32'h0);
    offer(OP_LOAD,   hi_pat, 3'(N_ACT - 1), hi_pat, 32'hFFFF_FFFF);
    // counter full
    offer(OP_RECORD, hi_pat, 3'(N_ACT - 1), hi_pat, 32'h0);
    offer(OP_READ,   hi_pat, 3'(N_ACT - 1), hi_pat, 32'h0);
    offer(OP_LOAD,   hi_pat, 3'(N_ACT - 1), hi_pat, 32'h0);
    offer(OP_LOAD,   lo_pat, 3'd1, hi_pat, 32'hFFFF_FFFE);
    offer(OP_RECORD, lo_pat, 3'd1, hi_pat, 32'h0);
    offer(OP_RECORD, lo_pat, 3'd1, hi_pat, 32'h0);
    // rejected requests, then one valid read
    offer(OP_RECORD, lo_pat, 3'(N_ACT), lo_pat, 32'h0);
    offer(OP_READ,   lo_pat, 3'd7, lo_pat, 32'h0);
    offer(OP_NONE,   lo_pat, 3'd0, lo_pat, 32'h0);
    offer(OP_RECORD, 14'h0000, 3'd0, lo_pat, 32'h0);
    offer(OP_RECORD, lo_pat, 3'd0, 14'h3FFF, 32'h0);
    offer(OP_RECORD, lo_pat | 14'h0002, 3'd0, lo_pat, 32'h0);
    offer(OP_READ,   lo_pat & ~14'h0020, 3'd0, lo_pat, 32'h0);
    offer(OP_LOAD,   lo_pat, 3'd0, lo_pat | 14'h1000, 32'h1234_5678);
    offer(OP_NONE,   14'h3FFF, 3'd7, 14'h0000, 32'hFFFF_FFFF);
    offer(OP_READ,   lo_pat, 3'd0, lo_pat, 32'h0);

    // sender pauses until the pipe is empty
    drain();
    send_idle_on  <= 1'b1;
    sink_stall_on <= 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) begin
        long_hold    <= 1'b1;
        send_idle_on <= 1'b0;
      end
      if (i == 260) send_idle_on <= 1'b1;
      if (i == 450) drain();
      if (i % 100 == 99) begin
        pool_cur[i % POOL_SIZE]  = any_valid_pattern();
        pool_next[i % POOL_SIZE] = any_valid_pattern();
      end
      if (i == N_RANDOM - CALM_TAIL) begin
        send_idle_on  <= 1'b0;
        sink_stall_on <= 1'b0;
      end
      random_request();
      sender_gap();
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
